// ----- rtl/pcrc_pkg.sv -----
// Package for the cksum CRC-32 block: transfer types, queue constants,
// back-end state encoding and the byte-wise CRC step.
// No dependencies.
package pcrc_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } item_t;

    typedef struct packed {
        logic [31:0] checksum;
        logic [31:0] message_length;
        logic        length_overflow;
    } result_t;

    typedef struct packed {
        logic full;
        logic not_empty;
    } queue_status_t;

    typedef enum logic {
        BACK_RUN,
        BACK_TAIL
    } back_state_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  byte_in);
        logic [31:0] crc;
        crc = crc_in ^ {byte_in, 24'h0};
        for (int k = 0; k < 8; k++) begin
            if (crc[31]) begin
                crc = {crc[30:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[30:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

// ----- rtl/posix_cksum_crc32.sv -----
// POSIX cksum CRC-32 block.
// Input channel item/item_valid/item_stall: one transfer per cycle carries at
// most one message byte and an end-of-message mark. Items with neither are
// dropped at the front end.
// Output channel result/result_valid/result_stall: one transfer per message
// with the complemented CRC, the saturated length and the overflow flag.
// Throughput: one message byte per cycle while the back end is in BACK_RUN,
// set by its single CRC byte step per cycle. A byte enters the queue first
// and is then popped into crc_reg. Message end: the end mark is taken, each
// significant length byte is appended (0 to LENGTH_BITS/8), then the result
// register is loaded; the next message's bytes queue up meanwhile.
// When result_stall holds the result, the back end finishes the current
// message and its length tail and waits; the two-entry queue then fills and
// item_stall rises.
// Reset (rst_n low, asynchronous) empties the queue, clears CRC, counter and
// overflow flag and drops any pending result.
// Depends on pcrc_pkg, pcrc_front, pcrc_queue, pcrc_back.
module posix_cksum_crc32 #(
    parameter int unsigned LENGTH_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pcrc_pkg::item_t    item,
    input  logic               item_valid,
    output logic               item_stall,
    output pcrc_pkg::result_t  result,
    output logic               result_valid,
    input  logic               result_stall
);

    pcrc_pkg::queue_status_t qstat;
    pcrc_pkg::item_t         push_data;
    pcrc_pkg::item_t         head;
    logic                    push;
    logic                    pop;

    pcrc_front u_front (
        .item       (item),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .qstat      (qstat),
        .push       (push),
        .push_data  (push_data)
    );

    pcrc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .qstat     (qstat)
    );

    pcrc_back #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .qstat        (qstat),
        .pop          (pop),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

endmodule

// ----- rtl/pcrc_front.sv -----
// Front end: accepts item transfers, drops idle items and pushes the rest
// into the command queue. Depends on pcrc_pkg.
module pcrc_front (
    input  pcrc_pkg::item_t         item,
    input  logic                    item_valid,
    output logic                    item_stall,
    input  pcrc_pkg::queue_status_t qstat,
    output logic                    push,
    output pcrc_pkg::item_t         push_data
);

    logic useful;

    assign useful     = item.byte_present | item.end_of_message;
    assign item_stall = qstat.full;
    assign push       = item_valid & ~qstat.full & useful;
    assign push_data  = item;

endmodule

// ----- rtl/pcrc_queue.sv -----
// Short command queue between front and back end.
// Depends on pcrc_pkg.
module pcrc_queue (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  pcrc_pkg::item_t         push_data,
    input  logic                    pop,
    output pcrc_pkg::item_t         head,
    output pcrc_pkg::queue_status_t qstat
);

    pcrc_pkg::item_t                   mem [pcrc_pkg::QUEUE_DEPTH];
    logic [pcrc_pkg::QPTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [pcrc_pkg::QPTR_BITS-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [pcrc_pkg::QCNT_BITS-1:0]    count_reg, count_next;
    logic                              do_push, do_pop;

    assign qstat.full      = (count_reg == pcrc_pkg::QCNT_BITS'(pcrc_pkg::QUEUE_DEPTH));
    assign qstat.not_empty = (count_reg != '0);
    assign do_push         = push & ~qstat.full;
    assign do_pop          = pop & qstat.not_empty;
    assign head            = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- rtl/pcrc_back.sv -----
// Back end: folds bytes into the CRC, counts them, appends the length at
// message end and holds the result register. Depends on pcrc_pkg.
module pcrc_back #(
    parameter int unsigned LENGTH_BITS = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  pcrc_pkg::item_t         head,
    input  pcrc_pkg::queue_status_t qstat,
    output logic                    pop,
    output pcrc_pkg::result_t       result,
    output logic                    result_valid,
    input  logic                    result_stall
);

    localparam int unsigned EXT_BITS = (LENGTH_BITS > 32) ? LENGTH_BITS : 32;

    pcrc_pkg::back_state_t   state_reg, state_next;
    logic [31:0]             crc_reg, crc_next;
    logic [LENGTH_BITS-1:0]  counter_reg, counter_next;
    logic                    sat_reg, sat_next;
    logic [LENGTH_BITS-1:0]  rest_reg, rest_next;
    logic                    result_valid_reg, result_valid_next;
    pcrc_pkg::result_t       result_reg, result_next;
    logic [EXT_BITS-1:0]     count_ext;
    logic [31:0]             length_sat;
    logic [31:0]             crc_upd;
    logic                    slot_free;

    assign count_ext    = EXT_BITS'(counter_reg);
    assign length_sat   = (count_ext > EXT_BITS'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                : count_ext[31:0];
    assign slot_free    = ~result_valid_reg | ~result_stall;
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    always_comb
    begin
        state_next        = state_reg;
        crc_next          = crc_reg;
        counter_next      = counter_reg;
        sat_next          = sat_reg;
        rest_next         = rest_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg & result_stall;
        pop               = 1'b0;
        crc_upd           = pcrc_pkg::crc_byte(crc_reg, head.data_byte);

        unique case (state_reg)
            pcrc_pkg::BACK_RUN:
            begin
                if (qstat.not_empty) begin
                    pop = 1'b1;
                    if (head.byte_present) begin
                        crc_next = crc_upd;
                        if (&counter_reg) begin
                            sat_next = 1'b1;
                        end else begin
                            counter_next = counter_reg + LENGTH_BITS'(1);
                        end
                    end
                    if (head.end_of_message) begin
                        rest_next  = counter_next;
                        state_next = pcrc_pkg::BACK_TAIL;
                    end
                end
            end
            pcrc_pkg::BACK_TAIL:
            begin
                if (rest_reg != '0) begin
                    crc_next  = pcrc_pkg::crc_byte(crc_reg, rest_reg[7:0]);
                    rest_next = rest_reg >> 8;
                end else if (slot_free) begin
                    result_next.checksum        = ~crc_reg;
                    result_next.message_length  = length_sat;
                    result_next.length_overflow = sat_reg;
                    result_valid_next           = 1'b1;
                    crc_next                    = '0;
                    counter_next                = '0;
                    sat_next                    = 1'b0;
                    state_next                  = pcrc_pkg::BACK_RUN;
                end
            end
            default:
            begin
                state_next = pcrc_pkg::BACK_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= pcrc_pkg::BACK_RUN;
            crc_reg          <= '0;
            counter_reg      <= '0;
            sat_reg          <= 1'b0;
            rest_reg         <= '0;
            result_valid_reg <= 1'b0;
        end else begin
            state_reg        <= state_next;
            crc_reg          <= crc_next;
            counter_reg      <= counter_next;
            sat_reg          <= sat_next;
            rest_reg         <= rest_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

endmodule

// ----- test/tb_top.sv -----
// Testbench for posix_cksum_crc32: directed and random messages, checked against
// a running CRC-32/length predictor, with random idling and a long output hold.
// Depends on pcrc_pkg and the posix_cksum_crc32 RTL.
module tb_top;

    localparam int unsigned LEN_BITS = 16;
    localparam logic [63:0] COUNT_FULL = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - LEN_BITS);
    localparam logic [31:0] GEN_POLY = 32'h04C1_1DB7;
    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int RANDOM_ITEMS = 300;
    localparam int SETTLE_CYCLES = 24;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    pcrc_pkg::item_t   item = '0;
    logic              item_valid = 1'b0;
    logic              item_stall;
    pcrc_pkg::result_t result;
    logic              result_valid;
    logic              result_stall = 1'b0;

    pcrc_pkg::result_t pending_sums[$];
    logic [31:0] run_crc = '0;
    logic [63:0] run_count = '0;
    logic        run_sat = 1'b0;
    int          mismatches = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    bit          idle_on = 1'b0;
    int          hold_pending = 0;
    int          hold_left = 0;
    int          stall_left = 0;

    posix_cksum_crc32 #(
        .LENGTH_BITS (LEN_BITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result       (result),
        .result_valid (result_valid),
        .result_stall (result_stall)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] r;
        r = acc ^ {b, 24'h0};
        repeat (8)
        begin
            if (r[31])
                r = {r[30:0], 1'b0} ^ GEN_POLY;
            else
                r = {r[30:0], 1'b0};
        end
        return r;
    endfunction

    function automatic pcrc_pkg::item_t mk_item(input logic [7:0] b, input logic p,
                                                input logic e);
        pcrc_pkg::item_t it;
        it.data_byte      = b;
        it.byte_present   = p;
        it.end_of_message = e;
        return it;
    endfunction

    // Running CRC and byte count; the count is appended LSB first on end of message.
    task automatic fold_item(input pcrc_pkg::item_t it);
        pcrc_pkg::result_t r;
        logic [31:0] crc;
        logic [63:0] tail;
        if (it.byte_present)
        begin
            run_crc = crc_step(run_crc, it.data_byte);
            if (run_count >= COUNT_FULL)
            begin
                run_count = COUNT_FULL;
                run_sat   = 1'b1;
            end
            else
                run_count++;
        end
        if (it.end_of_message)
        begin
            crc  = run_crc;
            tail = run_count;
            while (tail != 0)
            begin
                crc  = crc_step(crc, tail[7:0]);
                tail = tail >> 8;
            end
            r.checksum        = ~crc;
            r.message_length  = (run_count > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : run_count[31:0];
            r.length_overflow = run_sat;
            pending_sums.push_back(r);
            run_crc   = '0;
            run_count = '0;
            run_sat   = 1'b0;
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0d: %s", cycle_count, what);
        mismatches++;
    endtask

    task automatic send_item(input pcrc_pkg::item_t it);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        fold_item(it);
        if (it.byte_present || it.end_of_message)
            items_sent++;
    endtask

    // n random bytes; end mark rides on the last byte or follows as its own transfer
    task automatic send_message(input int n_bytes, input bit mark_last, input int idle_pct);
        for (int i = 0; i < n_bytes; i++)
        begin
            if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
                send_item(mk_item(8'($urandom), 1'b0, 1'b0));
            send_item(mk_item(8'($urandom), 1'b1, mark_last && i == n_bytes - 1));
        end
        if (!mark_last || n_bytes == 0)
            send_item(mk_item(8'($urandom), 1'b0, 1'b1));
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_pending != 0)
        begin
            hold_left    = hold_pending;
            hold_pending = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            result_stall <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 8);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : check_results
        pcrc_pkg::result_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_sums.size() == 0)
                report_mismatch($sformatf("unexpected result %h", result));
            else
            begin
                want = pending_sums.pop_front();
                if (result.checksum !== want.checksum)
                    report_mismatch($sformatf("checksum %h, want %h",
                                              result.checksum, want.checksum));
                if (result.message_length !== want.message_length)
                    report_mismatch($sformatf("message_length %h, want %h",
                                              result.message_length, want.message_length));
                if (result.length_overflow !== want.length_overflow)
                    report_mismatch($sformatf("length_overflow %b, want %b",
                                              result.length_overflow, want.length_overflow));
            end
        end
    end

    task automatic wait_drained;
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending_sums.size() != 0) @(posedge clk);
    endtask

    task automatic test_empty_messages;
        send_item(mk_item(8'h00, 1'b0, 1'b1));
        send_item(mk_item(8'hFF, 1'b0, 1'b1));
    endtask

    task automatic test_single_bytes;
        send_item(mk_item(8'h00, 1'b1, 1'b1));
        send_item(mk_item(8'hFF, 1'b1, 1'b1));
        send_item(mk_item(8'h80, 1'b1, 1'b1));
        send_item(mk_item(8'h01, 1'b1, 1'b0));
        send_item(mk_item(8'h55, 1'b0, 1'b1));
    endtask

    task automatic test_known_string;
        send_item(mk_item(8'hAA, 1'b0, 1'b0));
        for (int i = 0; i < 9; i++)
        begin
            send_item(mk_item(8'(8'h31 + i), 1'b1, 1'b0));
            if (i == 4)
                send_item(mk_item(8'hFF, 1'b0, 1'b0));
        end
        send_item(mk_item(8'h00, 1'b0, 1'b1));
    endtask

    // 256 bytes: two appended length bytes, the low one zero
    task automatic test_length_tail;
        send_message(256, 1'b0, 0);
    endtask

    task automatic test_output_hold;
        idle_on = 1'b0;
        hold_pending = 400;
        for (int i = 0; i < 12; i++)
            send_message($urandom_range(0, 5), 1'($urandom_range(0, 1)), 0);
        wait_drained();
    endtask

    task automatic test_random_traffic;
        pcrc_pkg::item_t it;
        idle_on = 1'b1;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= RANDOM_ITEMS - 120)
                idle_on = 1'b0;
            if ($urandom_range(0, 9) == 0)
            begin
                it = mk_item(8'($urandom), 1'($urandom), 1'($urandom));
                send_item(it);
            end
            else if ($urandom_range(0, 19) == 0)
                send_message($urandom_range(13, 300), 1'($urandom_range(0, 1)), 10);
            else
                send_message($urandom_range(0, 12), 1'($urandom_range(0, 1)), 10);
        end
        send_item(mk_item(8'($urandom), 1'b0, 1'b1));
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_messages();
        test_single_bytes();
        test_known_string();
        idle_on = 1'b1;
        test_length_tail();
        test_output_hold();
        test_random_traffic();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/pcrc_pkg.sv
rtl/pcrc_front.sv
rtl/pcrc_queue.sv
rtl/pcrc_back.sv
rtl/posix_cksum_crc32.sv
test/tb_top.sv
